### rtl/fco_pkg.sv
// Shared types, constants and helper functions for the fly camera core.
// Used by fco_cordic and fly_camera_orientation_update_core; no dependencies.
`default_nettype none

package fco_pkg;

  // Default build values for the top-level parameters
  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int POSITION_WIDTH_DEF = 32;

  // Angles in 1/128 degree
  localparam logic [16:0] TURN        = 17'd46080;
  localparam logic [16:0] QUARTER     = 17'd11520;
  localparam logic [16:0] EIGHTH      = 17'd5760;
  localparam logic signed [29:0] PITCH_MAX = 30'sd11392;
  localparam logic signed [29:0] PITCH_MIN = -30'sd11392;
  localparam logic [15:0] YAW_RESET   = 16'd34560;

  // Zoom limits, Q6.8 degrees
  localparam logic signed [21:0] ZOOM_MIN = 22'sd256;
  localparam logic signed [21:0] ZOOM_MAX = 22'sd11520;

  // Configuration register indexes and reset values
  localparam logic REG_MOVE_SPEED = 1'b0;
  localparam logic REG_LOOK_SENS  = 1'b1;
  localparam logic [15:0] MOVE_SPEED_RESET = 16'd640;
  localparam logic [15:0] LOOK_SENS_RESET  = 16'd26;

  // Event kinds
  localparam logic [1:0] OP_MOVE = 2'd0;
  localparam logic [1:0] OP_LOOK = 2'd1;
  localparam logic [1:0] OP_ZOOM = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Move directions
  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  // Unit vector bounds, Q1.15
  localparam logic signed [15:0] UNIT_MAX = 16'sd32767;
  localparam logic signed [15:0] UNIT_MIN = -16'sd32767;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         move_direction;
    logic [15:0]        frame_dt;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic [13:0]        zoom_level;
  } rsp_t;

  // Sine/cosine result, scale 1.0 = 32768
  typedef struct packed {
    logic signed [17:0] cos_v;
    logic signed [17:0] sin_v;
  } trig_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PREP,
    CS_ITER,
    CS_OUT
  } cordic_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ZOOM,
    S_MV_MUL0,
    S_MV_DIST,
    S_MV_MUL,
    S_MV_ACC,
    S_LK_MULX,
    S_LK_MULY,
    S_LK_PITCH,
    S_LK_WRAP,
    S_LK_FIX,
    S_CY_START,
    S_CY_WAIT,
    S_CP_START,
    S_CP_WAIT,
    S_BS_MUL,
    S_BS_STORE,
    S_DONE
  } core_state_t;

  // Arctangent of 2^-i in 1/65536 degree
  function automatic logic signed [24:0] atan_step(input logic [4:0] idx);
    logic signed [24:0] v;
    unique case (idx)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  // Clamp to the Q1.15 unit range
  function automatic logic signed [15:0] unit_clamp(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'(UNIT_MAX)) begin
      r = UNIT_MAX;
    end else if (v < 20'(UNIT_MIN)) begin
      r = UNIT_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/fly_camera_orientation_update_core.sv
// Fly camera core: event sequencer, shared multiplier, position/angle/zoom state.
// Depends on fco_pkg and fco_cordic.
//
//  port group   dir   contents
//  cmd          in    event word (cmd_t), cmd_valid / cmd_stall
//  rsp          out   position, basis and zoom word (rsp_t), rsp_valid / rsp_stall
//  apb          in    move_speed at 0x0, look_sensitivity at 0x4
//
// A look runs a 12-step turn wrap, two passes through the CORDIC and four basis
// products through the one 26x18 multiplier. One event is in work at a time;
// cmd_stall is high from acceptance until the result is loaded into the output
// register. rst is synchronous; a held rsp_stall holds the next result back.
`default_nettype none

module fly_camera_orientation_update_core
  import fco_pkg::*;
#(
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Storage holds the reset z of 3.0 even for narrow saturation widths
  localparam int POS_SW = (POSITION_WIDTH > 19) ? POSITION_WIDTH : 19;
  localparam int SUM_W  = ((POS_SW > 26) ? POS_SW : 26) + 1;
  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W - POSITION_WIDTH + 1){1'b0}}, {(POSITION_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN =
    {{(SUM_W - POSITION_WIDTH + 1){1'b1}}, {(POSITION_WIDTH - 1){1'b0}}};
  localparam logic signed [POS_SW-1:0] POS_Z0 = POS_SW'(32'sd196608);

  core_state_t state, state_next;

  cmd_t               cur;
  logic [15:0]        speed, sens;
  logic [15:0]        yaw;
  logic signed [14:0] pitch;
  logic signed [POS_SW-1:0] pos [3];
  logic [13:0]        zoom;
  logic signed [15:0] basis [8];
  logic signed [43:0] prod;
  logic [23:0]        move_len;
  logic [1:0]         axis;
  logic signed [29:0] wrap_v;
  logic [3:0]         wrap_k;
  logic signed [17:0] cy, sy, cp, sp;
  logic [1:0]         bidx;

  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [15:0] comp_sel;
  logic               fb_move, neg;
  logic               cordic_start, cordic_done;
  logic signed [16:0] cordic_angle;
  trig_t              cordic_res;
  logic               cfg_wr;

  logic signed [43:0] rnd5, rnd8, rnd15;
  logic signed [29:0] look_d, pitch_sum, wrap_sh;
  logic signed [25:0] step_d;
  logic signed [SUM_W-1:0] pos_sum;
  logic signed [21:0] zoom_sum;
  logic signed [19:0] qm;
  logic signed [63:0] pos_ext [3];
  rsp_t               rsp_next;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_LOOK_SENS) ? {16'b0, sens} : {16'b0, speed};

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= MOVE_SPEED_RESET;
      sens  <= LOOK_SENS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MOVE_SPEED) begin
        speed <= pwdata[15:0];
      end else begin
        sens <= pwdata[15:0];
      end
    end
  end

  fco_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cordic_start),
    .angle(cordic_angle),
    .done (cordic_done),
    .res  (cordic_res)
  );

  assign cmd_stall    = (state != S_IDLE);
  assign cordic_start = (state == S_CY_START) || (state == S_CP_START);
  assign cordic_angle = (state == S_CY_START) ? $signed({1'b0, yaw}) : 17'(pitch);

  // Move axis selection
  assign fb_move  = (cur.move_direction == DIR_FORWARD) ||
                    (cur.move_direction == DIR_BACKWARD);
  assign neg      = (cur.move_direction == DIR_BACKWARD) ||
                    (cur.move_direction == DIR_LEFT);
  assign comp_sel = fb_move ? basis[{1'b0, axis}] : ((axis == 2'd0) ? basis[3] : basis[4]);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MV_MUL0: begin
        mul_a = {10'b0, speed};
        mul_b = {2'b0, cur.frame_dt};
      end
      S_MV_MUL: begin
        mul_a = {2'b0, move_len};
        mul_b = 18'(comp_sel);
      end
      S_LK_MULX: begin
        mul_a = 26'(cur.x_offset);
        mul_b = {2'b0, sens};
      end
      S_LK_MULY: begin
        mul_a = 26'(cur.y_offset);
        mul_b = {2'b0, sens};
      end
      S_BS_MUL: begin
        unique case (bidx)
          2'd0: begin
            mul_a = 26'(cy);
            mul_b = cp;
          end
          2'd1: begin
            mul_a = 26'(sy);
            mul_b = cp;
          end
          2'd2: begin
            mul_a = 26'(cy);
            mul_b = sp;
          end
          default: begin
            mul_a = 26'(sy);
            mul_b = sp;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding and range logic on the product
  always_comb begin
    rnd5      = (prod + 44'sd16) >>> 5;
    rnd8      = prod + 44'sd128;
    rnd15     = (prod + 44'sd16384) >>> 15;
    look_d    = rnd5[29:0];
    step_d    = rnd15[25:0];
    qm        = rnd15[19:0];
    pitch_sum = 30'(pitch) + look_d;
    wrap_sh   = 30'($signed({1'b0, TURN})) <<< wrap_k;
    pos_sum   = neg ? (SUM_W'(pos[axis]) - SUM_W'(step_d))
                    : (SUM_W'(pos[axis]) + SUM_W'(step_d));
    zoom_sum  = $signed({8'b0, zoom}) - (22'(cur.y_offset) <<< 4);
  end

  // Result word
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_ext[k] = 64'(pos[k]);
    end
    rsp_next.pos_x      = pos_ext[0][31:0];
    rsp_next.pos_y      = pos_ext[1][31:0];
    rsp_next.pos_z      = pos_ext[2][31:0];
    rsp_next.front_x    = basis[0];
    rsp_next.front_y    = basis[1];
    rsp_next.front_z    = basis[2];
    rsp_next.right_x    = basis[3];
    rsp_next.right_z    = basis[4];
    rsp_next.up_x       = basis[5];
    rsp_next.up_y       = basis[6];
    rsp_next.up_z       = basis[7];
    rsp_next.zoom_level = zoom;
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.opcode == OP_MOVE) begin
            state_next = S_MV_MUL0;
          end else if (cmd.opcode == OP_LOOK) begin
            state_next = S_LK_MULX;
          end else if (cmd.opcode == OP_ZOOM) begin
            state_next = S_ZOOM;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ZOOM:     state_next = S_DONE;
      S_MV_MUL0:  state_next = S_MV_DIST;
      S_MV_DIST:  state_next = S_MV_MUL;
      S_MV_MUL:   state_next = S_MV_ACC;
      S_MV_ACC:   state_next = (axis == 2'd2) ? S_DONE : S_MV_MUL;
      S_LK_MULX:  state_next = S_LK_MULY;
      S_LK_MULY:  state_next = S_LK_PITCH;
      S_LK_PITCH: state_next = S_LK_WRAP;
      S_LK_WRAP:  if (wrap_k == 4'd0) state_next = S_LK_FIX;
      S_LK_FIX:   state_next = S_CY_START;
      S_CY_START: state_next = S_CY_WAIT;
      S_CY_WAIT:  if (cordic_done) state_next = S_CP_START;
      S_CP_START: state_next = S_CP_WAIT;
      S_CP_WAIT:  if (cordic_done) state_next = S_BS_MUL;
      S_BS_MUL:   state_next = S_BS_STORE;
      S_BS_STORE: state_next = (bidx == 2'd3) ? S_DONE : S_BS_MUL;
      S_DONE:     if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      yaw       <= YAW_RESET;
      pitch     <= '0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= POS_Z0;
      zoom      <= 14'(ZOOM_MAX);
      basis[0]  <= '0;
      basis[1]  <= '0;
      basis[2]  <= UNIT_MIN;
      basis[3]  <= UNIT_MAX;
      basis[4]  <= '0;
      basis[5]  <= '0;
      basis[6]  <= UNIT_MAX;
      basis[7]  <= '0;
    end else begin
      state <= state_next;
      // Hand the result to the output register, drop it once taken
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_ZOOM: begin
          if (zoom_sum < ZOOM_MIN) begin
            zoom <= 14'(ZOOM_MIN);
          end else if (zoom_sum > ZOOM_MAX) begin
            zoom <= 14'(ZOOM_MAX);
          end else begin
            zoom <= zoom_sum[13:0];
          end
        end
        S_MV_ACC: begin
          if (pos_sum > POS_MAX) begin
            pos[axis] <= POS_SW'(POS_MAX);
          end else if (pos_sum < POS_MIN) begin
            pos[axis] <= POS_SW'(POS_MIN);
          end else begin
            pos[axis] <= POS_SW'(pos_sum);
          end
        end
        S_LK_PITCH: begin
          if (pitch_sum > PITCH_MAX) begin
            pitch <= 15'(PITCH_MAX);
          end else if (pitch_sum < PITCH_MIN) begin
            pitch <= 15'(PITCH_MIN);
          end else begin
            pitch <= pitch_sum[14:0];
          end
        end
        S_LK_FIX: begin
          yaw <= wrap_v[29] ? 16'(wrap_v + 30'($signed({1'b0, TURN}))) : wrap_v[15:0];
        end
        S_BS_STORE: begin
          unique case (bidx)
            2'd0: basis[0] <= unit_clamp(qm);
            2'd1: basis[2] <= unit_clamp(qm);
            2'd2: basis[5] <= unit_clamp(-qm);
            default: begin
              basis[7] <= unit_clamp(-qm);
              basis[1] <= unit_clamp(20'(sp));
              basis[3] <= unit_clamp(-20'(sy));
              basis[4] <= unit_clamp(20'(cy));
              basis[6] <= unit_clamp(20'(cp));
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) cur <= cmd;
      end
      S_MV_DIST: begin
        move_len <= rnd8[31:8];
        axis     <= 2'd0;
      end
      S_MV_ACC: begin
        axis <= (fb_move && axis == 2'd0) ? 2'd1 : 2'd2;
      end
      S_LK_MULY: begin
        wrap_v <= 30'($signed({1'b0, yaw})) + look_d;
        wrap_k <= 4'd11;
      end
      S_LK_WRAP: begin
        // Fold one power-of-two multiple of the turn per cycle
        if (wrap_v >= wrap_sh) begin
          wrap_v <= wrap_v - wrap_sh;
        end else if (wrap_v[29]) begin
          wrap_v <= wrap_v + wrap_sh;
        end
        wrap_k <= wrap_k - 1'b1;
      end
      S_CY_WAIT: begin
        if (cordic_done) begin
          cy <= cordic_res.cos_v;
          sy <= cordic_res.sin_v;
        end
      end
      S_CP_WAIT: begin
        if (cordic_done) begin
          cp   <= cordic_res.cos_v;
          sp   <= cordic_res.sin_v;
          bidx <= 2'd0;
        end
      end
      S_BS_STORE: begin
        bidx <= bidx + 1'b1;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) rsp <= rsp_next;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/fco_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of an angle in 1/128 degree.
// Depends on fco_pkg (angle constants, arctangent table, result type).
`default_nettype none

module fco_cordic
  import fco_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] angle,
  output logic                    done,
  output trig_t                   res
);

  localparam int IW = $clog2(STEPS);
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);
  // Q4.30 start value with the gain folded in
  localparam logic signed [33:0] X0 = 34'sd652032874;

  cordic_state_t state, state_next;

  logic [15:0]        m;
  logic [1:0]         q;
  logic               zero;
  logic signed [33:0] x, y;
  logic signed [24:0] z;
  logic [IW-1:0]      i;

  logic [2:0]         qf;
  logic signed [16:0] r;
  logic signed [33:0] dx, dy;
  logic signed [24:0] da;
  logic signed [17:0] cc, ss;
  trig_t              mapped;

  function automatic logic signed [17:0] round_clamp(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] o;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32768) begin
      o = 18'sd32768;
    end else if (t < -34'sd32768) begin
      o = -18'sd32768;
    end else begin
      o = t[17:0];
    end
    return o;
  endfunction

  // Quadrant and residual around the nearest multiple of 90 degrees
  always_comb begin
    qf = 3'(m >= 16'(EIGHTH)) + 3'(m >= 16'd17280) + 3'(m >= 16'd28800)
       + 3'(m >= 16'd40320);
    unique case (qf)
      3'd0:    r = $signed({1'b0, m});
      3'd1:    r = $signed({1'b0, m}) - $signed(QUARTER);
      3'd2:    r = $signed({1'b0, m}) - 17'sd23040;
      3'd3:    r = $signed({1'b0, m}) - 17'sd34560;
      default: r = $signed({1'b0, m}) - $signed(TURN);
    endcase
  end

  // One micro-rotation
  always_comb begin
    dx = y >>> i;
    dy = x >>> i;
    da = atan_step(5'(i));
  end

  // Round, then map the quadrant back
  always_comb begin
    if (zero) begin
      cc = 18'sd32768;
      ss = 18'sd0;
    end else begin
      cc = round_clamp(x);
      ss = round_clamp(y);
    end
    unique case (q)
      2'd0: begin
        mapped.cos_v = cc;
        mapped.sin_v = ss;
      end
      2'd1: begin
        mapped.cos_v = -ss;
        mapped.sin_v = cc;
      end
      2'd2: begin
        mapped.cos_v = -cc;
        mapped.sin_v = -ss;
      end
      default: begin
        mapped.cos_v = ss;
        mapped.sin_v = -cc;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: if (start) state_next = CS_PREP;
      CS_PREP: state_next = CS_ITER;
      CS_ITER: if (i == LAST) state_next = CS_OUT;
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == CS_OUT);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      CS_IDLE: begin
        if (start) begin
          m <= angle[16] ? 16'(angle + $signed(TURN)) : angle[15:0];
        end
      end
      CS_PREP: begin
        q    <= qf[1:0];
        zero <= (r == 17'sd0);
        x    <= X0;
        y    <= 34'sd0;
        z    <= 25'(r) <<< 9;
        i    <= '0;
      end
      CS_ITER: begin
        if (!z[24]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - da;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + da;
        end
        i <= i + 1'b1;
      end
      default: begin
        res <= mapped;
      end
    endcase
  end

endmodule

`default_nettype wire
